FILE: rtl/ranked_top_n_insert_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ranked top-N insertion table
// Implication checks sampled on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RANKED_TOP_N_INSERT_TABLE_TOP_ASSERT_SVH
`define RANKED_TOP_N_INSERT_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define RTNT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTNT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rtnt_pkg.sv
// ----------------------------------------------------------------------------
// rtnt_pkg
// Shared types, constants and helpers of the ranked top-N insertion table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtnt_pkg;

    localparam int TABLES         = 3;
    localparam int ENTRIES_DEF    = 10;
    localparam int NAME_CHARS_DEF = 8;
    localparam int STEP_SCORE     = 1000;

    localparam int SCORE_W = 32;
    localparam int NAME_W  = 64;
    localparam int IDX_W   = 6;
    localparam int TSEL_W  = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // default names, first character in the low byte; unused select reads zero
    localparam logic [NAME_W-1:0] DEFAULT_NAMES [4] = '{
        64'h65676E696C6C6F68,
        64'h73736F685F6E6573,
        64'h0000006F68676573,
        64'h0000000000000000
    };

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [NAME_W-1:0]         name;
    } t_entry;

    function automatic logic [NAME_W-1:0] f_name_mask(input int chars);
        logic [NAME_W-1:0] m;
        if (chars >= NAME_W / 8) begin
            m = '1;
        end else begin
            m = (64'd1 << (chars * 8)) - 64'd1;
        end
        return m;
    endfunction

    // score held at a rank after reset
    function automatic logic [SCORE_W-1:0] f_reset_score(input int entries,
                                                         input logic [IDX_W-1:0] pos);
        int diff;
        diff = entries - int'(pos);
        return SCORE_W'(diff * STEP_SCORE);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rtnt_store.sv
// ----------------------------------------------------------------------------
// rtnt_store
// Entry memory of all tables: one write and one registered read per cycle.
// Entries never written since reset read back as their reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnt_store #(
    parameter int ENTRIES    = rtnt_pkg::ENTRIES_DEF,
    parameter int NAME_CHARS = rtnt_pkg::NAME_CHARS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_we,
    input  wire logic [rtnt_pkg::TSEL_W-1:0] i_wtab,
    input  wire logic [rtnt_pkg::IDX_W-1:0]  i_wpos,
    input  wire rtnt_pkg::t_entry           i_wdata,
    input  wire logic [rtnt_pkg::TSEL_W-1:0] i_rtab,
    input  wire logic [rtnt_pkg::IDX_W-1:0]  i_rpos,
    output rtnt_pkg::t_entry                o_rdata
);
    import rtnt_pkg::*;

    localparam int TOTAL = TABLES * ENTRIES;
    localparam int AW    = $clog2(TOTAL);
    localparam logic [NAME_W-1:0] NAME_MASK = f_name_mask(NAME_CHARS);

    t_entry                r_mem [TOTAL];
    logic [TOTAL-1:0]      r_vld;
    t_entry                r_rd_raw;
    logic                  r_rd_vld;
    logic [TSEL_W-1:0]     r_rd_tab;
    logic [IDX_W-1:0]      r_rd_pos;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;

    assign w_waddr = AW'(int'(i_wtab) * ENTRIES + int'(i_wpos));
    assign w_raddr = AW'(int'(i_rtab) * ENTRIES + int'(i_rpos));

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_waddr] <= i_wdata;
        end
        r_rd_raw <= r_mem[w_raddr];
        r_rd_tab <= i_rtab;
        r_rd_pos <= i_rpos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[w_raddr];
        end
    end

    always_comb begin
        if (r_rd_vld) begin
            o_rdata = r_rd_raw;
        end else begin
            o_rdata.score = f_reset_score(ENTRIES, r_rd_pos);
            o_rdata.name  = DEFAULT_NAMES[r_rd_tab] & NAME_MASK;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ranked_top_n_insert_table_top.sv
// ----------------------------------------------------------------------------
// ranked_top_n_insert_table_top
// Three sorted score tables with insert and read transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction: an insert
//   (i_mode = 0) of score and name into table i_table_select, or a read
//   (i_mode = 1) of rank i_read_index. Output channel (o_out_valid /
//   i_out_ready) returns exactly one result per transaction.
//   An insert walks the selected table one rank per cycle through a single
//   compare unit and the one-read/one-write entry memory, writing the new
//   entry and shifting the lower ones down in the same pass. An insert passes
//   through S_FETCH, the walk and S_DONE to o_out_valid, a read through S_FETCH
//   and S_DONE, an invalid table select or read index through S_DONE only. One
//   transaction is in work at a time; o_in_ready returns with o_out_valid.
//   Reset restores every table to its default contents at once (per-entry
//   valid bits), so transactions are accepted right after reset.
//   A stalled result holds in the output register; the next transaction
//   finishes its walk, then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ranked_top_n_insert_table_top_assert.svh"

module ranked_top_n_insert_table_top #(
    parameter int ENTRIES    = rtnt_pkg::ENTRIES_DEF,
    parameter int NAME_CHARS = rtnt_pkg::NAME_CHARS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_mode,
    input  wire logic [rtnt_pkg::TSEL_W-1:0]        i_table_select,
    input  wire logic signed [rtnt_pkg::SCORE_W-1:0] i_new_score,
    input  wire logic [rtnt_pkg::NAME_W-1:0]        i_new_name,
    input  wire logic [rtnt_pkg::IDX_W-1:0]         i_read_index,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_placed,
    output logic [rtnt_pkg::IDX_W-1:0]              o_rank,
    output logic signed [rtnt_pkg::SCORE_W-1:0]     o_entry_score,
    output logic [rtnt_pkg::NAME_W-1:0]             o_entry_name
);
    import rtnt_pkg::*;

    localparam logic [NAME_W-1:0] NAME_MASK = f_name_mask(NAME_CHARS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_WALK,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_mode, n_mode;
    logic                     r_skip, n_skip;
    logic [TSEL_W-1:0]        r_tab, n_tab;
    logic [IDX_W-1:0]         r_pos, n_pos;
    logic signed [SCORE_W-1:0] r_score, n_score;
    logic [NAME_W-1:0]        r_name, n_name;
    t_entry                   r_held, n_held;
    logic                     r_placed, n_placed;
    logic [IDX_W-1:0]         r_rank, n_rank;
    logic                     r_out_valid, n_out_valid;
    logic                     r_out_placed, n_out_placed;
    logic [IDX_W-1:0]         r_out_rank, n_out_rank;
    logic signed [SCORE_W-1:0] r_out_score, n_out_score;
    logic [NAME_W-1:0]        r_out_name, n_out_name;

    logic                     w_accept;
    logic                     w_we;
    t_entry                   w_wdata;
    logic [IDX_W-1:0]         w_rpos;
    t_entry                   w_rdata;
    logic                     w_last;
    logic                     w_slot_free;

    rtnt_store #(
        .ENTRIES    (ENTRIES),
        .NAME_CHARS (NAME_CHARS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_wtab  (r_tab),
        .i_wpos  (r_pos),
        .i_wdata (w_wdata),
        .i_rtab  (r_tab),
        .i_rpos  (w_rpos),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last      = (int'(r_pos) >= ENTRIES - 1);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // during the walk, fetch the next rank while the current one is written
    always_comb begin
        if (r_state == S_WALK && !w_last) begin
            w_rpos = r_pos + IDX_W'(1);
        end else begin
            w_rpos = r_pos;
        end
    end

    // write the new entry at the first lower score, then ripple the held one
    assign w_we    = (r_state == S_WALK) && (r_placed || (w_rdata.score < r_score));
    assign w_wdata = r_placed ? r_held : t_entry'{score: r_score, name: r_name};

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_skip       = r_skip;
        n_tab        = r_tab;
        n_pos        = r_pos;
        n_score      = r_score;
        n_name       = r_name;
        n_held       = r_held;
        n_placed     = r_placed;
        n_rank       = r_rank;
        n_out_valid  = r_out_valid;
        n_out_placed = r_out_placed;
        n_out_rank   = r_out_rank;
        n_out_score  = r_out_score;
        n_out_name   = r_out_name;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_mode   = i_mode;
                    n_tab    = i_table_select;
                    n_score  = i_new_score;
                    n_name   = i_new_name & NAME_MASK;
                    n_placed = 1'b0;
                    n_rank   = '0;
                    n_pos    = (i_mode == MODE_READ) ? i_read_index : '0;
                    n_skip   = (int'(i_table_select) >= TABLES) ||
                               ((i_mode == MODE_READ) && (int'(i_read_index) >= ENTRIES));
                    n_state  = n_skip ? S_DONE : S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = (r_mode == MODE_READ) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (w_we) begin
                    n_held = w_rdata;
                    if (!r_placed) begin
                        n_placed = 1'b1;
                        n_rank   = r_pos;
                    end
                end
                if (w_last) begin
                    n_state = S_DONE;
                end else begin
                    n_pos = r_pos + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_placed = 1'b0;
                    n_out_rank   = '0;
                    n_out_score  = '0;
                    n_out_name   = '0;
                    if (!r_skip) begin
                        if (r_mode == MODE_READ) begin
                            n_out_score = w_rdata.score;
                            n_out_name  = w_rdata.name;
                        end else begin
                            n_out_placed = r_placed;
                            n_out_rank   = r_rank;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_skip       <= n_skip;
        r_tab        <= n_tab;
        r_pos        <= n_pos;
        r_score      <= n_score;
        r_name       <= n_name;
        r_held       <= n_held;
        r_placed     <= n_placed;
        r_rank       <= n_rank;
        r_out_placed <= n_out_placed;
        r_out_rank   <= n_out_rank;
        r_out_score  <= n_out_score;
        r_out_name   <= n_out_name;
    end

    assign o_out_valid   = r_out_valid;
    assign o_placed      = r_out_placed;
    assign o_rank        = r_out_rank;
    assign o_entry_score = r_out_score;
    assign o_entry_name  = r_out_name;

    `RTNT_ASSERT_IMP(a_rank_in_table, i_clk, i_rst_n,
        o_out_valid && o_placed, int'(o_rank) < ENTRIES,
        "placed rank beyond table")
    `RTNT_ASSERT_IMP(a_write_in_walk, i_clk, i_rst_n,
        w_we, (r_state == S_WALK) && (int'(r_pos) < ENTRIES),
        "table write outside walk")
    `RTNT_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n,
        w_accept, !o_in_ready,
        "ready right after accept")
    `RTNT_ASSERT_IMP(a_read_not_placed, i_clk, i_rst_n,
        o_out_valid && (o_entry_score != '0), !o_placed,
        "read result marked placed")

endmodule

`default_nettype wire
